>>> sv/nnc_pkg.sv
// Package: shared constants, codes and the command type of the nearest-neighbour classifier.
`timescale 1ns / 1ps
`default_nettype none
package nnc_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int COORD_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam int PORT_COORD_W = 16;
	localparam int LIMIT_W      = 34;
	localparam int OUT_IDX_W    = 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd10000;

	// Action codes
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NO_MATCH = 2'd2;

	typedef struct packed {
		logic [1:0]                   action;
		logic [3:0][PORT_COORD_W-1:0] coords;
		logic                         label;
	} cmd_t;

endpackage
`default_nettype wire

>>> sv/nnc_ifs.sv
// Interfaces: input, result and configuration channels of the classifier.
`timescale 1ns / 1ps
`default_nettype none
interface nnc_in_if import nnc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              action;
	logic [PORT_COORD_W-1:0] coord_0;
	logic [PORT_COORD_W-1:0] coord_1;
	logic [PORT_COORD_W-1:0] coord_2;
	logic [PORT_COORD_W-1:0] coord_3;
	logic                    class_label;

	modport source (output valid, action, coord_0, coord_1, coord_2, coord_3, class_label,
		input ready);
	modport sink (input valid, action, coord_0, coord_1, coord_2, coord_3, class_label,
		output ready);
endinterface

interface nnc_out_if import nnc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic                 nearest_label;
	logic [OUT_IDX_W-1:0] nearest_index;
	logic [LIMIT_W-1:0]   nearest_distance;

	modport source (output valid, status, nearest_label, nearest_index, nearest_distance,
		input ready);
	modport sink (input valid, status, nearest_label, nearest_index, nearest_distance,
		output ready);
endinterface

interface nnc_cfg_if import nnc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] distance_limit;

	modport source (output valid, distance_limit, input ready);
	modport sink (input valid, distance_limit, output ready);
endinterface
`default_nettype wire

>>> sv/nearest_neighbor_classifier_top.sv
// Top level of the nearest-neighbour classifier: front end, command queue, back end.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to MAX_POINTS labelled 4-D points and answers 1-NN queries against them.
// Clear, append and unused action codes present their result in the result register
// once the item has passed the front-end register and the queue. A query reads the table
// through the single read port of the point memory, one stored point per cycle, and its
// result is presented once the scan pipeline has drained; the front end keeps taking
// up to three further items (its own register and a two-entry queue) meanwhile.
// The distance limit may be written whenever no item is in flight.
module nearest_neighbor_classifier_top import nnc_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nnc_in_if.sink    in_ch,
	nnc_cfg_if.sink   cfg_ch,
	nnc_out_if.source out_ch
);

	cmd_t               fe_cmd;
	logic               fe_valid;
	logic               fe_ready;
	cmd_t               q_cmd;
	logic               q_valid;
	logic               q_ready;
	logic [LIMIT_W-1:0] limit_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			limit_q <= cfg_ch.distance_limit;
		end
	end

	nnc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cmd      (fe_cmd),
		.cmd_valid(fe_valid),
		.cmd_ready(fe_ready)
	);

	nnc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cmd  (fe_cmd),
		.push_valid(fe_valid),
		.push_ready(fe_ready),
		.pop_cmd   (q_cmd),
		.pop_valid (q_valid),
		.pop_ready (q_ready)
	);

	nnc_back #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (q_cmd),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.limit    (limit_q),
		.out_ch   (out_ch)
	);

	a_no_match_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_NO_MATCH |->
			out_ch.nearest_distance == '0 && out_ch.nearest_index == '0
			&& !out_ch.nearest_label)
		else $error("no-match result carries a non-zero field");

	a_match_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |->
			out_ch.nearest_distance == '0 || out_ch.nearest_distance < limit_q)
		else $error("reported distance not below the limit");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_FULL |->
			out_ch.nearest_distance == '0 && out_ch.nearest_index == '0)
		else $error("dropped append carries a non-zero field");

endmodule
`default_nettype wire

>>> sv/nnc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> sv/nnc_front.sv
// Front end: accept items, sign-extend the coordinates, pass the label on and issue commands.
`timescale 1ns / 1ps
`default_nettype none
module nnc_front import nnc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nnc_in_if.sink    in_ch,
	output cmd_t      cmd,
	output logic      cmd_valid,
	input  wire logic cmd_ready
);

	localparam int SH = PORT_COORD_W - COORD_BITS;

	cmd_t cmd_q;
	logic cmd_v_q;
	cmd_t cmd_new;
	logic accept;

	function automatic logic [PORT_COORD_W-1:0] sext(input logic [PORT_COORD_W-1:0] raw);
		logic signed [PORT_COORD_W-1:0] tmp;
		tmp = $signed(raw << SH);
		return tmp >>> SH;
	endfunction

	always_comb begin
		cmd_new.action    = in_ch.action;
		cmd_new.coords[0] = sext(in_ch.coord_0);
		cmd_new.coords[1] = sext(in_ch.coord_1);
		cmd_new.coords[2] = sext(in_ch.coord_2);
		cmd_new.coords[3] = sext(in_ch.coord_3);
		cmd_new.label     = in_ch.class_label;
	end

	assign in_ch.ready = !cmd_v_q || cmd_ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign cmd         = cmd_q;
	assign cmd_valid   = cmd_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_q <= 1'b0;
		end else if (accept) begin
			cmd_v_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_new;
		end
	end

endmodule
`default_nettype wire

>>> sv/nnc_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module nnc_queue import nnc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t push_cmd,
	input  wire logic push_valid,
	output logic      push_ready,
	output cmd_t      pop_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q < CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= advance(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= advance(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

>>> sv/nnc_back.sv
// Back end: table maintenance, pipelined distance scan and the result register.
`timescale 1ns / 1ps
`default_nettype none
module nnc_back import nnc_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire logic [LIMIT_W-1:0] limit,
	nnc_out_if.source               out_ch
);

	localparam int CB     = COORD_BITS;
	localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int WORD_W = 4 * CB + 1;
	localparam int SQ_W   = 2 * CB;
	localparam int DIST_W = 2 * CB + 2;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       scan_q;
	logic [3:0][CB-1:0]     qry_q;
	logic [LIMIT_W-1:0]     best_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic                   best_lab_q;
	logic                   found_q;

	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic                   label_q;
	logic [OUT_IDX_W-1:0]   index_q;
	logic [LIMIT_W-1:0]     dist_q;

	logic                   out_free;
	logic                   pop;
	logic                   full;
	logic                   issue;
	logic                   pipe_busy;
	logic                   better;
	logic [31:0]            best_idx_ext;

	logic                   wr_en;
	logic [WORD_W-1:0]      wr_word;
	logic [WORD_W-1:0]      rd_word;

	// Scan pipeline
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]       idx_s1, idx_s2, idx_s3, idx_s4;
	logic                   lab_s2, lab_s3, lab_s4;
	logic [3:0][CB-1:0]     abs_s2;
	logic [3:0][SQ_W-1:0]   sq_s3;
	logic [DIST_W-1:0]      sum_s4;
	logic [3:0][CB-1:0]     abs_d;
	logic [3:0][SQ_W-1:0]   sq_d;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign cmd_ready = (state_q == S_IDLE) && out_free;
	assign pop       = cmd_valid && cmd_ready;
	assign full      = count_q >= CNT_W'(MAX_POINTS);
	assign issue     = (state_q == S_SCAN) && (scan_q < count_q);
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign better    = v_s4 && (LIMIT_W'(sum_s4) < best_q);
	assign best_idx_ext = 32'(best_idx_q);
	assign wr_en     = pop && (cmd.action == ACT_APPEND) && !full;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			wr_word[k*CB +: CB] = cmd.coords[k][CB-1:0];
		end
		wr_word[WORD_W-1] = cmd.label;
	end

	nnc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(wr_word),
		.rd_en  (issue),
		.rd_addr(scan_q[IDX_W-1:0]),
		.rd_data(rd_word)
	);

	always_comb begin
		logic signed [CB:0] diff;
		logic signed [CB:0] mag;
		for (int k = 0; k < 4; k++) begin
			diff = $signed({rd_word[k*CB+CB-1], rd_word[k*CB +: CB]})
				- $signed({qry_q[k][CB-1], qry_q[k]});
			mag  = diff[CB] ? -diff : diff;
			abs_d[k] = mag[CB-1:0];
			sq_d[k]  = SQ_W'(abs_s2[k]) * SQ_W'(abs_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		lab_s2 <= rd_word[WORD_W-1];
		lab_s3 <= lab_s2;
		lab_s4 <= lab_s3;
		abs_s2 <= abs_d;
		sq_s3  <= sq_d;
		sum_s4 <= DIST_W'(sq_s3[0]) + DIST_W'(sq_s3[1]) + DIST_W'(sq_s3[2])
			+ DIST_W'(sq_s3[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			qry_q       <= '0;
			best_q      <= '0;
			best_idx_q  <= '0;
			best_lab_q  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			label_q     <= 1'b0;
			index_q     <= '0;
			dist_q      <= '0;
		end else begin
			// Drop a result once it has been taken
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						status_q <= ST_OK;
						label_q  <= 1'b0;
						index_q  <= '0;
						dist_q   <= '0;
						case (cmd.action)
							ACT_CLEAR: begin
								count_q     <= '0;
								out_valid_q <= 1'b1;
							end
							ACT_APPEND: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
								out_valid_q <= 1'b1;
							end
							ACT_QUERY: begin
								for (int k = 0; k < 4; k++) begin
									qry_q[k] <= cmd.coords[k][CB-1:0];
								end
								best_q     <= limit;
								best_idx_q <= '0;
								best_lab_q <= 1'b0;
								found_q    <= 1'b0;
								scan_q     <= '0;
								state_q    <= S_SCAN;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					// Strict compare keeps the earliest point on a tie
					if (better) begin
						best_q     <= LIMIT_W'(sum_s4);
						best_idx_q <= idx_s4;
						best_lab_q <= lab_s4;
						found_q    <= 1'b1;
					end
					if (!issue && !pipe_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= found_q ? ST_OK : ST_NO_MATCH;
						label_q     <= found_q && best_lab_q;
						index_q     <= found_q ? best_idx_ext[OUT_IDX_W-1:0] : '0;
						dist_q      <= found_q ? best_q : '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.status           = status_q;
	assign out_ch.nearest_label    = label_q;
	assign out_ch.nearest_index    = index_q;
	assign out_ch.nearest_distance = dist_q;

endmodule
`default_nettype wire

>>> tb/sv/tb_nearest_neighbor_classifier_top.sv
// Testbench: directed and random checking of the nearest-neighbour classifier.
`timescale 1ns / 1ps
`default_nettype none
module tb_nearest_neighbor_classifier_top;
	import nnc_pkg::*;

	localparam int                 TABLE_DEPTH = MAX_POINTS_DEF;
	localparam int                 CYCLE_LIMIT = 2000000;
	localparam logic [1:0]         ACT_UNUSED  = 2'd3;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX   = '1;

	typedef logic [3:0][PORT_COORD_W-1:0] point_t;

	typedef struct packed {
		logic [1:0]           status;
		logic                 label;
		logic [OUT_IDX_W-1:0] index;
		logic [LIMIT_W-1:0]   distance;
	} verdict_t;

	logic clk;
	logic arst_n;

	nnc_in_if  in_if ();
	nnc_out_if out_if ();
	nnc_cfg_if cfg_if ();

	nearest_neighbor_classifier_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.cfg_ch (cfg_if),
		.out_ch (out_if)
	);

	// Mirror of the block's table and limit register
	point_t             stored_points [TABLE_DEPTH];
	logic               stored_labels [TABLE_DEPTH];
	int                 stored_count;
	logic [LIMIT_W-1:0] limit_value;

	verdict_t expected_verdicts [$];
	int       mismatches = 0;
	int       cycles = 0;
	bit       sender_idles;
	bit       receiver_idles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [LIMIT_W-1:0] squared_distance(point_t a, point_t b);
		longint acc;
		longint diff;
		acc = 0;
		for (int k = 0; k < 4; k++) begin
			diff = longint'($signed(a[k])) - longint'($signed(b[k]));
			acc += diff * diff;
		end
		return acc[LIMIT_W-1:0];
	endfunction

	// Update the table mirror and return the result the item must produce
	function automatic verdict_t classify_item(cmd_t c);
		verdict_t           v;
		logic [LIMIT_W-1:0] best;
		logic [LIMIT_W-1:0] d;
		bit                 found;
		v = '0;
		case (c.action)
			ACT_CLEAR: stored_count = 0;
			ACT_APPEND: begin
				if (stored_count >= TABLE_DEPTH) begin
					v.status = ST_FULL;
				end else begin
					stored_points[stored_count] = c.coords;
					stored_labels[stored_count] = c.label;
					stored_count++;
				end
			end
			ACT_QUERY: begin
				best = limit_value;
				found = 1'b0;
				// strict compare keeps the earliest of equal distances
				for (int i = 0; i < stored_count; i++) begin
					d = squared_distance(stored_points[i], c.coords);
					if (d < best) begin
						best = d;
						v.index = i[OUT_IDX_W-1:0];
						v.label = stored_labels[i];
						found = 1'b1;
					end
				end
				if (found)
					v.distance = best;
				else
					v.status = ST_NO_MATCH;
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic int idle_gap(bit enabled);
		int roll;
		roll = $urandom_range(0, 99);
		if (!enabled || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic point_t make_point(int a, int b, int c, int d);
		point_t p;
		p[0] = a[15:0];
		p[1] = b[15:0];
		p[2] = c[15:0];
		p[3] = d[15:0];
		return p;
	endfunction

	function automatic point_t random_point();
		return {$urandom(), $urandom()};
	endfunction

	function automatic point_t near_point(point_t base, int radius);
		point_t p;
		int     off;
		for (int k = 0; k < 4; k++) begin
			off = int'($urandom_range(0, 2 * radius)) - radius;
			p[k] = base[k] + off[15:0];
		end
		return p;
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] action, point_t p, logic label);
		cmd_t c;
		c.action = action;
		c.coords = p;
		c.label = label;
		return c;
	endfunction

	// Called at a falling edge; returns at a falling edge with valid still high
	// when no gap follows, so the next item goes out back to back.
	task automatic send_item(cmd_t c);
		int gap;
		in_if.valid = 1'b1;
		in_if.action = c.action;
		in_if.coord_0 = c.coords[0];
		in_if.coord_1 = c.coords[1];
		in_if.coord_2 = c.coords[2];
		in_if.coord_3 = c.coords[3];
		in_if.class_label = c.label;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		expected_verdicts.insert(expected_verdicts.size(), classify_item(c));
		gap = idle_gap(sender_idles);
		@(negedge clk);
		if (gap > 0) begin
			in_if.valid = 1'b0;
			in_if.action = $urandom_range(0, 3);
			in_if.coord_0 = $urandom();
			in_if.coord_3 = $urandom();
			repeat (gap)
				@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_if.valid = 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_distance_limit(logic [LIMIT_W-1:0] value);
		wait_drained();
		cfg_if.valid = 1'b1;
		cfg_if.distance_limit = value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		limit_value = value;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		verdict_t got;
		verdict_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got.status = out_if.status;
			got.label = out_if.nearest_label;
			got.index = out_if.nearest_index;
			got.distance = out_if.nearest_distance;
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d label %0d index %0d distance %0d",
						got.status, got.label, got.index, got.distance);
			end else begin
				want = expected_verdicts.pop_front();
				if (got.status !== want.status || got.label !== want.label ||
					got.index !== want.index || got.distance !== want.distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected status %0d label %0d index %0d ",
							"distance %0d, got status %0d label %0d index %0d distance %0d"},
							want.status, want.label, want.index, want.distance,
							got.status, got.label, got.index, got.distance);
				end
			end
		end
	end

	initial begin : receiver
		int hold;
		hold = 0;
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else
				hold = idle_gap(receiver_idles);
			out_if.ready = (hold == 0);
		end
	end

	task automatic test_directed_cases();
		point_t low_corner;
		point_t high_corner;
		point_t mixed;
		low_corner = {4{16'h8000}};
		high_corner = {4{16'h7fff}};
		mixed = make_point(-5, 7, -32768, 32767);
		write_distance_limit(LIMIT_RESET);
		send_item(make_cmd(ACT_QUERY, '0, 1'b0));
		send_item(make_cmd(ACT_UNUSED, random_point(), 1'b1));
		send_item(make_cmd(ACT_APPEND, '0, 1'b1));
		send_item(make_cmd(ACT_APPEND, make_point(100, 0, 0, 0), 1'b0));
		send_item(make_cmd(ACT_QUERY, make_point(100, 0, 0, 0), 1'b1));
		// a distance equal to the limit misses, one below it hits
		send_item(make_cmd(ACT_QUERY, make_point(200, 0, 0, 0), 1'b0));
		send_item(make_cmd(ACT_QUERY, make_point(199, 0, 0, 0), 1'b0));
		// duplicate of the first point: ties must go to the earlier entry
		send_item(make_cmd(ACT_APPEND, '0, 1'b0));
		send_item(make_cmd(ACT_QUERY, make_point(-1, 0, 0, 0), 1'b0));
		send_item(make_cmd(ACT_QUERY, make_point(50, 0, 0, 0), 1'b1));
		send_item(make_cmd(ACT_UNUSED, make_point(1, 0, 0, 0), 1'b0));
		send_item(make_cmd(ACT_QUERY, make_point(0, 0, 0, 1), 1'b0));
		send_item(make_cmd(ACT_CLEAR, random_point(), 1'b1));
		send_item(make_cmd(ACT_QUERY, '0, 1'b0));
		send_item(make_cmd(ACT_APPEND, low_corner, 1'b1));
		write_distance_limit(LIMIT_MAX);
		send_item(make_cmd(ACT_QUERY, high_corner, 1'b0));
		send_item(make_cmd(ACT_APPEND, high_corner, 1'b0));
		send_item(make_cmd(ACT_APPEND, mixed, 1'b1));
		send_item(make_cmd(ACT_QUERY, '0, 1'b0));
		send_item(make_cmd(ACT_QUERY, mixed, 1'b0));
		write_distance_limit('0);
		send_item(make_cmd(ACT_QUERY, low_corner, 1'b0));
		write_distance_limit(1);
		send_item(make_cmd(ACT_QUERY, low_corner, 1'b0));
		send_item(make_cmd(ACT_CLEAR, '0, 1'b0));
	endtask

	task automatic test_full_table();
		write_distance_limit(LIMIT_MAX);
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		send_item(make_cmd(ACT_CLEAR, random_point(), 1'b0));
		// overfill: the last few appends must be dropped
		for (int n = 0; n < TABLE_DEPTH + 3; n++)
			send_item(make_cmd(ACT_APPEND, random_point(), $urandom_range(0, 1)));
		send_item(make_cmd(ACT_QUERY, stored_points[TABLE_DEPTH-1], 1'b0));
		send_item(make_cmd(ACT_QUERY, stored_points[0], 1'b1));
		repeat (4)
			send_item(make_cmd(ACT_QUERY, random_point(), $urandom_range(0, 1)));
		send_item(make_cmd(ACT_CLEAR, random_point(), 1'b1));
		send_item(make_cmd(ACT_QUERY, random_point(), 1'b0));
	endtask

	task automatic test_random_traffic(int items, logic [LIMIT_W-1:0] limit, int spread);
		point_t centre;
		point_t base;
		int     cap;
		int     roll;
		int     radius;
		cmd_t   c;
		write_distance_limit(limit);
		sender_idles = $urandom_range(0, 3) != 0;
		receiver_idles = $urandom_range(0, 3) != 0;
		centre = random_point();
		cap = $urandom_range(4, 48);
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 4 || stored_count > cap) begin
				c = make_cmd(ACT_CLEAR, random_point(), $urandom_range(0, 1));
				cap = $urandom_range(4, 48);
			end else if (roll < 8) begin
				c = make_cmd(ACT_UNUSED, random_point(), $urandom_range(0, 1));
			end else if (roll < 12) begin
				c = make_cmd(ACT_QUERY, random_point(), $urandom_range(0, 1));
			end else if (roll < 50) begin
				// repeat a stored point now and then so that ties come up
				if (stored_count > 0 && roll < 18)
					base = stored_points[$urandom_range(0, stored_count - 1)];
				else
					base = near_point(centre, spread);
				c = make_cmd(ACT_APPEND, base, $urandom_range(0, 1));
			end else begin
				radius = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, spread);
				if (stored_count > 0)
					base = near_point(stored_points[$urandom_range(0, stored_count - 1)], radius);
				else
					base = near_point(centre, spread);
				c = make_cmd(ACT_QUERY, base, $urandom_range(0, 1));
			end
			send_item(c);
		end
	endtask

	initial begin
		in_if.valid = 1'b0;
		in_if.action = ACT_CLEAR;
		in_if.coord_0 = '0;
		in_if.coord_1 = '0;
		in_if.coord_2 = '0;
		in_if.coord_3 = '0;
		in_if.class_label = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.distance_limit = LIMIT_RESET;
		stored_count = 0;
		limit_value = LIMIT_RESET;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		arst_n = 1'b0;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_full_table();
		test_random_traffic(90, LIMIT_RESET, 40);
		test_random_traffic(90, {$urandom_range(0, 3), $urandom()}, 20000);
		test_random_traffic(60, '0, 10);
		test_random_traffic(90, LIMIT_MAX, 30000);
		test_random_traffic(90, 1, 2);
		test_random_traffic(90, $urandom_range(1, 1 << 20), 300);
		test_random_traffic(90, LIMIT_RESET, 60);

		wait_drained();
		repeat (20)
			@(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
